@@ hw/rtl/triangle_mesh_vertex_decoder_defines.svh @@
// assertion helpers for the vertex decoder checker
`ifndef TRIANGLE_MESH_VERTEX_DECODER_DEFINES_SVH
`define TRIANGLE_MESH_VERTEX_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TMVD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vertex decoder check failed");

// next-cycle implication, checked outside reset
`define TMVD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vertex decoder check failed");

`endif

@@ hw/rtl/tmvd_pkg.sv @@
`default_nettype none
package tmvd_pkg;

   localparam int MaxComponents = 4;
   localparam int CoordBits     = 24;
   localparam int ColourBits    = 16;
   localparam int ValueBits     = 32;
   localparam int CountBits     = 3;
   localparam int PosBits       = 4;
   localparam int ProductBits   = ValueBits + CoordBits;

   // divisor of the coordinate map and its rounding bias
   localparam logic [CoordBits-1:0]   COORD_MAX  = 24'hFF_FFFF;
   localparam logic [ProductBits-1:0] ROUND_BIAS = 56'h7F_FFFF;

   // record flag codes
   localparam logic [7:0] FLAG_NEW          = 8'd0;
   localparam logic [7:0] FLAG_REPEAT_LAST  = 8'd1;
   localparam logic [7:0] FLAG_REPEAT_FIRST = 8'd2;

   // short form of the flag kept with a queued record
   localparam logic [1:0] KIND_NEW          = 2'd0;
   localparam logic [1:0] KIND_REPEAT_LAST  = 2'd1;
   localparam logic [1:0] KIND_REPEAT_FIRST = 2'd2;

   // csr register indexes
   localparam logic [2:0] REG_COMPONENT_COUNT = 3'd0;
   localparam logic [2:0] REG_X_RANGE_LOW     = 3'd1;
   localparam logic [2:0] REG_X_RANGE_HIGH    = 3'd2;
   localparam logic [2:0] REG_Y_RANGE_LOW     = 3'd3;
   localparam logic [2:0] REG_Y_RANGE_HIGH    = 3'd4;

   typedef logic [ColourBits-1:0] colour_type;
   typedef colour_type [MaxComponents-1:0] colours_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [CoordBits-1:0] raw_x;
      logic [CoordBits-1:0] raw_y;
      colours_type          colour;
   } record_type;

   typedef struct packed {
      logic signed [ValueBits-1:0] x;
      logic signed [ValueBits-1:0] y;
      colours_type                 colour;
   } vertex_type;

   typedef struct packed {
      logic signed [ValueBits-1:0] x_low;
      logic signed [ValueBits-1:0] x_high;
      logic signed [ValueBits-1:0] y_low;
      logic signed [ValueBits-1:0] y_high;
   } ranges_type;

endpackage
`default_nettype wire

@@ hw/rtl/triangle_mesh_vertex_decoder.sv @@
// Throughput: one byte per cycle while the two-entry record queue has room.
// The back end maps a record through its DIFF, MUL, DIV1, DIV2 and ADD states, then gives
// one result or three in its OUT state, and takes no new record until it is back in IDLE.
// Reset is synchronous and active high; it restores the csr defaults and clears
// the byte position, the queue, the vertex history and the result valid flag.
`default_nettype none
module triangle_mesh_vertex_decoder (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [7:0]         req_stream_byte,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_vertex_x,
   output logic signed [31:0]      rsp_vertex_y,
   output logic [15:0]             rsp_colour_a,
   output logic [15:0]             rsp_colour_b,
   output logic [15:0]             rsp_colour_c,
   output logic [15:0]             rsp_colour_d,
   output logic                    rsp_run_end,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata
);
   import tmvd_pkg::*;

   logic [CountBits-1:0] count_ff, count_in;
   ranges_type           ranges_ff, ranges_in;
   logic [CountBits-1:0] count_eff;
   logic                 push_valid;
   logic                 push_ready;
   record_type           push_record;
   logic                 pop_valid;
   logic                 pop_ready;
   record_type           pop_record;

   // csr writes
   always_comb begin
      count_in  = count_ff;
      ranges_in = ranges_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_COMPONENT_COUNT: count_in         = csr_wdata[CountBits-1:0];
            REG_X_RANGE_LOW:     ranges_in.x_low  = csr_wdata;
            REG_X_RANGE_HIGH:    ranges_in.x_high = csr_wdata;
            REG_Y_RANGE_LOW:     ranges_in.y_low  = csr_wdata;
            REG_Y_RANGE_HIGH:    ranges_in.y_high = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= CountBits'(3);
         ranges_ff.x_low  <= '0;
         ranges_ff.x_high <= 32'sh0001_0000;
         ranges_ff.y_low  <= '0;
         ranges_ff.y_high <= 32'sh0001_0000;
      end else begin
         count_ff  <= count_in;
         ranges_ff <= ranges_in;
      end
   end

   // zero acts as one, anything above the maximum as the maximum
   assign count_eff = (count_ff == '0) ? CountBits'(1)
                    : (count_ff > CountBits'(MaxComponents)) ? CountBits'(MaxComponents)
                    : count_ff;

   tmvd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .component_count (count_eff),
      .push_valid      (push_valid),
      .push_record     (push_record),
      .push_ready      (push_ready)
   );

   tmvd_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_record (push_record),
      .push_ready  (push_ready),
      .pop_valid   (pop_valid),
      .pop_record  (pop_record),
      .pop_ready   (pop_ready)
   );

   tmvd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_record   (pop_record),
      .pop_ready    (pop_ready),
      .ranges       (ranges_ff),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_vertex_x (rsp_vertex_x),
      .rsp_vertex_y (rsp_vertex_y),
      .rsp_colour_a (rsp_colour_a),
      .rsp_colour_b (rsp_colour_b),
      .rsp_colour_c (rsp_colour_c),
      .rsp_colour_d (rsp_colour_d),
      .rsp_run_end  (rsp_run_end)
   );

endmodule
`default_nettype wire

@@ hw/rtl/tmvd_front.sv @@
`default_nettype none
module tmvd_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [7:0]               req_stream_byte,
   input  wire logic [2:0]               component_count,
   output logic                          push_valid,
   output tmvd_pkg::record_type          push_record,
   input  wire logic                     push_ready
);
   import tmvd_pkg::*;

   logic [PosBits-1:0]   pos_ff, pos_in;
   logic [7:0]           flag_ff, flag_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [CoordBits-1:0] raw_x_ff, raw_x_in, raw_y_ff, raw_y_in;
   colours_type          colour_ff, colour_in;
   logic                 accept;
   logic                 last;
   logic [PosBits-1:0]   last_pos;
   logic [PosBits-1:0]   comp_offset;
   logic [1:0]           comp_index;

   assign req_ready   = push_ready;
   assign accept      = req_valid & push_ready;
   assign last_pos    = PosBits'(6) + {count_ff, 1'b0};
   assign last        = (pos_ff != '0) && (pos_ff == last_pos);
   assign comp_offset = pos_ff - PosBits'(7);
   assign comp_index  = comp_offset[2:1];

   // field assembly, one byte per word
   always_comb begin
      pos_in    = pos_ff;
      flag_in   = flag_ff;
      count_in  = count_ff;
      raw_x_in  = raw_x_ff;
      raw_y_in  = raw_y_ff;
      colour_in = colour_ff;
      if (accept) begin
         if (pos_ff == '0) begin
            flag_in  = req_stream_byte;
            count_in = component_count;
         end else if (pos_ff <= PosBits'(3)) begin
            raw_x_in = {raw_x_ff[CoordBits-9:0], req_stream_byte};
         end else if (pos_ff <= PosBits'(6)) begin
            raw_y_in = {raw_y_ff[CoordBits-9:0], req_stream_byte};
         end else begin
            colour_in[comp_index] = {colour_ff[comp_index][ColourBits-9:0], req_stream_byte};
         end
         pos_in = last ? '0 : pos_ff + PosBits'(1);
      end
   end

   // hand a finished record with a known flag to the queue
   always_comb begin
      push_valid         = accept & last & (flag_ff <= FLAG_REPEAT_FIRST);
      push_record.kind   = flag_ff[1:0];
      push_record.raw_x  = raw_x_ff;
      push_record.raw_y  = raw_y_ff;
      for (int i = 0; i < MaxComponents; i++) begin
         push_record.colour[i] = (CountBits'(i) < count_ff) ? colour_in[i] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         flag_ff   <= '0;
         count_ff  <= CountBits'(1);
         raw_x_ff  <= '0;
         raw_y_ff  <= '0;
         colour_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         flag_ff   <= flag_in;
         count_ff  <= count_in;
         raw_x_ff  <= raw_x_in;
         raw_y_ff  <= raw_y_in;
         colour_ff <= colour_in;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/tmvd_queue.sv @@
`default_nettype none
module tmvd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  tmvd_pkg::record_type  push_record,
   output logic                  push_ready,
   output logic                  pop_valid,
   output tmvd_pkg::record_type  pop_record,
   input  wire logic             pop_ready
);
   import tmvd_pkg::*;

   record_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   logic       pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_record = entry_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_record;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/tmvd_back.sv @@
`default_nettype none
module tmvd_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    pop_valid,
   input  tmvd_pkg::record_type         pop_record,
   output logic                         pop_ready,
   input  tmvd_pkg::ranges_type         ranges,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [31:0]           rsp_vertex_x,
   output logic signed [31:0]           rsp_vertex_y,
   output logic [15:0]                  rsp_colour_a,
   output logic [15:0]                  rsp_colour_b,
   output logic [15:0]                  rsp_colour_c,
   output logic [15:0]                  rsp_colour_d,
   output logic                         rsp_run_end
);
   import tmvd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DIFF = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_DIV1 = 3'd3;
   localparam logic [2:0] S_DIV2 = 3'd4;
   localparam logic [2:0] S_ADD  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]             state_ff, state_in;
   record_type             rec_ff, rec_in;
   logic                   neg_ff [2];
   logic                   neg_in [2];
   logic [ValueBits-1:0]   mag_ff [2];
   logic [ValueBits-1:0]   mag_in [2];
   logic [ProductBits-1:0] prod_ff [2];
   logic [ProductBits-1:0] prod_in [2];
   logic [ValueBits-1:0]   high_ff [2];
   logic [ValueBits-1:0]   high_in [2];
   logic [ValueBits:0]     fold_ff [2];
   logic [ValueBits:0]     fold_in [2];
   logic [ValueBits-1:0]   quot_ff [2];
   logic [ValueBits-1:0]   quot_in [2];
   vertex_type             nv_ff, nv_in;
   vertex_type             hist_ff [3];
   vertex_type             hist_in [3];
   logic [1:0]             idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   vertex_type             rsp_vtx_ff, rsp_vtx_in;
   logic                   rsp_end_ff, rsp_end_in;

   logic signed [ValueBits-1:0] lo [2];
   logic signed [ValueBits-1:0] hi [2];
   logic [CoordBits-1:0]        raw [2];
   logic signed [ValueBits:0]   diff [2];
   logic [ProductBits-1:0]      biased [2];
   logic [8:0]                  fold_hi [2];
   logic [CoordBits:0]          fold_sum [2];
   logic [ValueBits:0]          mapped [2];
   logic                        load;
   vertex_type                  first_vtx;
   vertex_type                  sel_vtx;

   assign lo[0]  = ranges.x_low;
   assign lo[1]  = ranges.y_low;
   assign hi[0]  = ranges.x_high;
   assign hi[1]  = ranges.y_high;
   assign raw[0] = rec_ff.raw_x;
   assign raw[1] = rec_ff.raw_y;

   // per-coordinate datapath pieces, x in lane 0 and y in lane 1
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         diff[i]     = {hi[i][ValueBits-1], hi[i]} - {lo[i][ValueBits-1], lo[i]};
         biased[i]   = prod_ff[i] + ROUND_BIAS;
         fold_hi[i]  = fold_ff[i][ValueBits:CoordBits];
         fold_sum[i] = {16'd0, fold_hi[i]} + {1'b0, fold_ff[i][CoordBits-1:0]};
         mapped[i]   = neg_ff[i] ? {lo[i][ValueBits-1], lo[i]} - {1'b0, quot_ff[i]}
                                 : {lo[i][ValueBits-1], lo[i]} + {1'b0, quot_ff[i]};
      end
   end

   assign pop_ready = (state_ff == S_IDLE);
   assign load      = ~rsp_valid_ff | rsp_ready;
   assign first_vtx = (rec_ff.kind == KIND_REPEAT_LAST) ? hist_ff[1] : hist_ff[0];

   // vertex for the current slot of the run
   always_comb begin
      case (idx_ff)
         2'd0:    sel_vtx = first_vtx;
         2'd1:    sel_vtx = hist_ff[2];
         default: sel_vtx = nv_ff;
      endcase
   end

   // sequencer: map both coordinates, then play out the run
   always_comb begin
      state_in     = state_ff;
      rec_in       = rec_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      high_in      = high_ff;
      fold_in      = fold_ff;
      quot_in      = quot_ff;
      nv_in        = nv_ff;
      hist_in      = hist_ff;
      idx_in       = idx_ff;
      rsp_vtx_in   = rsp_vtx_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid) begin
               rec_in   = pop_record;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            // magnitude and sign of high minus low
            for (int i = 0; i < 2; i++) begin
               neg_in[i] = diff[i][ValueBits];
               mag_in[i] = diff[i][ValueBits] ? ValueBits'(-diff[i])
                                              : diff[i][ValueBits-1:0];
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            for (int i = 0; i < 2; i++) begin
               prod_in[i] = ProductBits'(mag_in[i]) * ProductBits'(raw[i]);
            end
            state_in = S_DIV1;
         end
         S_DIV1: begin
            // n = h*2^24 + l = h*(2^24-1) + (h + l)
            for (int i = 0; i < 2; i++) begin
               high_in[i] = biased[i][ProductBits-1:CoordBits];
               fold_in[i] = {1'b0, biased[i][ProductBits-1:CoordBits]}
                          + {9'd0, biased[i][CoordBits-1:0]};
            end
            state_in = S_DIV2;
         end
         S_DIV2: begin
            // second fold is below twice the divisor, one compare finishes it
            for (int i = 0; i < 2; i++) begin
               quot_in[i] = high_ff[i] + ValueBits'(fold_hi[i])
                          + ValueBits'(fold_sum[i] >= {1'b0, COORD_MAX});
            end
            state_in = S_ADD;
         end
         S_ADD: begin
            nv_in.x      = mapped[0][ValueBits-1:0];
            nv_in.y      = mapped[1][ValueBits-1:0];
            nv_in.colour = rec_ff.colour;
            idx_in       = (rec_ff.kind == KIND_NEW) ? 2'd2 : 2'd0;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (load) begin
               rsp_vtx_in   = sel_vtx;
               rsp_end_in   = (idx_ff == 2'd2);
               rsp_valid_in = 1'b1;
               if (idx_ff == 2'd2) begin
                  hist_in[0] = (rec_ff.kind == KIND_NEW) ? hist_ff[1] : first_vtx;
                  hist_in[1] = hist_ff[2];
                  hist_in[2] = nv_ff;
                  state_in   = S_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         for (int i = 0; i < 3; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         hist_ff      <= hist_in;
      end
   end

   // datapath registers, no reset
   always_ff @(posedge clock) begin
      rec_ff     <= rec_in;
      neg_ff     <= neg_in;
      mag_ff     <= mag_in;
      prod_ff    <= prod_in;
      high_ff    <= high_in;
      fold_ff    <= fold_in;
      quot_ff    <= quot_in;
      nv_ff      <= nv_in;
      rsp_vtx_ff <= rsp_vtx_in;
      rsp_end_ff <= rsp_end_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_vertex_x = rsp_vtx_ff.x;
   assign rsp_vertex_y = rsp_vtx_ff.y;
   assign rsp_colour_a = rsp_vtx_ff.colour[0];
   assign rsp_colour_b = rsp_vtx_ff.colour[1];
   assign rsp_colour_c = rsp_vtx_ff.colour[2];
   assign rsp_colour_d = rsp_vtx_ff.colour[3];
   assign rsp_run_end  = rsp_end_ff;

endmodule
`default_nettype wire

@@ hw/rtl/tmvd_checker.sv @@
`default_nettype none
`include "triangle_mesh_vertex_decoder_defines.svh"
module tmvd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_vertex_x,
   input wire logic [31:0] rsp_vertex_y,
   input wire logic        rsp_run_end
);

   // a stalled result word holds
   `TMVD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vertex_x) && $stable(rsp_vertex_y) && $stable(rsp_run_end))

   // nothing is offered right after reset
   `TMVD_ASSERT_NOW(a_rsp_idle_after_reset, $past(reset), !rsp_valid)

   // the queue is empty after reset, so bytes are taken at once
   `TMVD_ASSERT_NOW(a_req_open_after_reset, $past(reset), req_ready)

   // a repeated vertex is followed directly by the rest of its run
   `TMVD_ASSERT_NEXT(a_run_continues, rsp_valid && rsp_ready && !rsp_run_end, rsp_valid)

endmodule

bind triangle_mesh_vertex_decoder tmvd_checker u_tmvd_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_vertex_x (rsp_vertex_x),
   .rsp_vertex_y (rsp_vertex_y),
   .rsp_run_end  (rsp_run_end)
);
`default_nettype wire

@@ tb/vertex_check_pkg.sv @@
package vertex_check_pkg;
   import tmvd_pkg::*;

   // one predicted vertex together with its end-of-record marker
   typedef struct packed {
      vertex_type vtx;
      logic       run_end;
   } vertex_expect_t;

   class vertex_tracker;
      // shadow of the csr bank
      logic [CountBits-1:0]        count_reg;
      logic signed [ValueBits-1:0] x_low;
      logic signed [ValueBits-1:0] x_high;
      logic signed [ValueBits-1:0] y_low;
      logic signed [ValueBits-1:0] y_high;

      // record parser state
      int                   position;
      int                   latched_count;
      logic [7:0]           flag;
      logic [CoordBits-1:0] raw_x;
      logic [CoordBits-1:0] raw_y;
      colour_type           raw_colour [MaxComponents];

      // last three emitted vertices, [2] newest
      vertex_type history [3];

      vertex_expect_t expected_vertices [$];
      int unsigned    predicted_count;
      int unsigned    failures;

      function new();
         count_reg     = 3;
         x_low         = 0;
         x_high        = 32'sh0001_0000;
         y_low         = 0;
         y_high        = 32'sh0001_0000;
         position      = 0;
         latched_count = 1;
         flag          = '0;
         raw_x         = '0;
         raw_y         = '0;
         foreach (raw_colour[i]) raw_colour[i] = '0;
         foreach (history[i]) history[i] = '0;
         predicted_count = 0;
         failures        = 0;
      endfunction

      // components per record as the block will use them
      function int effective_count();
         int n;
         n = count_reg;
         if (n < 1) n = 1;
         if (n > MaxComponents) n = MaxComponents;
         return n;
      endfunction

      function int record_position();
         return position;
      endfunction

      function int pending();
         return expected_vertices.size();
      endfunction

      function void write_reg(logic [2:0] index, logic [31:0] data);
         case (index)
            REG_COMPONENT_COUNT: count_reg = data[CountBits-1:0];
            REG_X_RANGE_LOW:     x_low     = data;
            REG_X_RANGE_HIGH:    x_high    = data;
            REG_Y_RANGE_LOW:     y_low     = data;
            REG_Y_RANGE_HIGH:    y_high    = data;
            default: ;
         endcase
      endfunction

      // linear map of a raw coordinate onto [lo, hi], rounded to nearest
      function logic signed [ValueBits-1:0] map_axis(logic signed [ValueBits-1:0] lo,
                                                     logic signed [ValueBits-1:0] hi,
                                                     logic [CoordBits-1:0] raw);
         longint          span;
         longint unsigned mag;
         longint unsigned q;
         longint          sum;
         span = longint'(hi) - longint'(lo);
         mag  = (span < 0) ? -span : span;
         q    = (mag * raw + ROUND_BIAS) / COORD_MAX;
         sum  = (span < 0) ? longint'(lo) - longint'(q) : longint'(lo) + longint'(q);
         if (sum > 64'sd2147483647) sum = 64'sd2147483647;
         if (sum < -64'sd2147483648) sum = -64'sd2147483648;
         return sum[ValueBits-1:0];
      endfunction

      function void emit(vertex_type v, logic last);
         vertex_expect_t e;
         e.vtx     = v;
         e.run_end = last;
         expected_vertices.push_back(e);
         predicted_count++;
      endfunction

      // note one accepted stream word and predict what it releases
      function void take_byte(logic [7:0] b);
         vertex_type fresh;
         vertex_type first_rep;
         vertex_type last_rep;
         int         ci;
         int         i;
         if (position == 0) begin
            latched_count = effective_count();
            flag          = b;
         end else if (position <= 3) begin
            raw_x = {raw_x[CoordBits-9:0], b};
         end else if (position <= 6) begin
            raw_y = {raw_y[CoordBits-9:0], b};
         end else begin
            ci = (position - 7) / 2;
            if (ci < MaxComponents) raw_colour[ci] = {raw_colour[ci][7:0], b};
         end

         if (position < 6 + 2 * latched_count) begin
            position++;
            return;
         end
         position = 0;

         // unknown flags are consumed silently
         if (flag > FLAG_REPEAT_FIRST) return;

         fresh.x = map_axis(x_low, x_high, raw_x);
         fresh.y = map_axis(y_low, y_high, raw_y);
         for (i = 0; i < MaxComponents; i++)
            fresh.colour[i] = (i < latched_count) ? raw_colour[i] : '0;

         if (flag == FLAG_NEW) begin
            emit(fresh, 1'b1);
            history[0] = history[1];
            history[1] = history[2];
            history[2] = fresh;
         end else begin
            first_rep = (flag == FLAG_REPEAT_LAST) ? history[1] : history[0];
            last_rep  = history[2];
            emit(first_rep, 1'b0);
            emit(last_rep, 1'b0);
            emit(fresh, 1'b1);
            history[0] = first_rep;
            history[1] = last_rep;
            history[2] = fresh;
         end
      endfunction

      function void compare_field(string name, logic signed [63:0] want,
                                  logic signed [63:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      // check one accepted vertex against the oldest prediction
      function void match_vertex(logic signed [31:0] x, logic signed [31:0] y,
                                 logic [15:0] ca, logic [15:0] cb,
                                 logic [15:0] cc, logic [15:0] cd, logic last);
         vertex_expect_t want;
         if (expected_vertices.size() == 0) begin
            $error("vertex with none expected: x=%0d y=%0d", x, y);
            failures++;
            return;
         end
         want = expected_vertices.pop_front();
         compare_field("vertex_x", want.vtx.x, x);
         compare_field("vertex_y", want.vtx.y, y);
         compare_field("colour_a", want.vtx.colour[0], ca);
         compare_field("colour_b", want.vtx.colour[1], cb);
         compare_field("colour_c", want.vtx.colour[2], cc);
         compare_field("colour_d", want.vtx.colour[3], cd);
         compare_field("run_end", want.run_end, last);
      endfunction

      function void close_out();
         if (expected_vertices.size() != 0) begin
            $error("%0d expected vertices never arrived", expected_vertices.size());
            failures++;
         end
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
module tb_top;
   import tmvd_pkg::*;
   import vertex_check_pkg::*;

   localparam int          DRAIN_CYCLES   = 24;
   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam logic [7:0]  FLAG_ALL_ONES  = 8'hFF;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7FFF_FFFF;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_stream_byte = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_vertex_x;
   logic signed [31:0] rsp_vertex_y;
   logic [15:0]        rsp_colour_a;
   logic [15:0]        rsp_colour_b;
   logic [15:0]        rsp_colour_c;
   logic [15:0]        rsp_colour_d;
   logic               rsp_run_end;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   int unsigned   send_idle_pct = 38;
   int unsigned   recv_idle_pct = 84;
   int unsigned   cycle_count = 0;
   int unsigned   words_sent = 0;
   vertex_tracker tracker;

   triangle_mesh_vertex_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_colour_a    (rsp_colour_a),
      .rsp_colour_b    (rsp_colour_b),
      .rsp_colour_c    (rsp_colour_c),
      .rsp_colour_d    (rsp_colour_d),
      .rsp_run_end     (rsp_run_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_vertex(rsp_vertex_x, rsp_vertex_y, rsp_colour_a, rsp_colour_b,
                              rsp_colour_c, rsp_colour_d, rsp_run_end);
   end

   // push one stream word, with random gaps before it
   task automatic push_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (!req_ready);
      tracker.take_byte(b);
      words_sent++;
   endtask

   task automatic write_csr(input logic [2:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.write_reg(index, data);
   endtask

   // stop the stream, let every vertex come out and the back end settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_record(input logic [7:0] flag, input logic [23:0] rx,
                              input logic [23:0] ry, input colours_type col, input int n);
      int i;
      push_byte(flag);
      push_byte(rx[23:16]);
      push_byte(rx[15:8]);
      push_byte(rx[7:0]);
      push_byte(ry[23:16]);
      push_byte(ry[15:8]);
      push_byte(ry[7:0]);
      for (i = 0; i < n; i++) begin
         push_byte(col[i][15:8]);
         push_byte(col[i][7:0]);
      end
   endtask

   function automatic logic [23:0] pick_coord();
      int r;
      r = $urandom_range(7);
      if (r == 0) return '0;
      if (r == 1) return 24'hFF_FFFF;
      return 24'($urandom);
   endfunction

   function automatic colours_type pick_colours();
      colours_type col;
      int          i;
      for (i = 0; i < MaxComponents; i++) begin
         case ($urandom_range(7))
            0:       col[i] = '0;
            1:       col[i] = 16'hFFFF;
            default: col[i] = 16'($urandom);
         endcase
      end
      return col;
   endfunction

   // well-formed record, mostly known flags
   task automatic send_random_record();
      logic [7:0] flag;
      int         r;
      r = $urandom_range(99);
      if (r < 40)      flag = FLAG_NEW;
      else if (r < 65) flag = FLAG_REPEAT_LAST;
      else if (r < 90) flag = FLAG_REPEAT_FIRST;
      else             flag = 8'($urandom_range(255, FLAG_REPEAT_FIRST + 1));
      send_record(flag, pick_coord(), pick_coord(), pick_colours(), tracker.effective_count());
   endtask

   // fill out whatever record the stream is in the middle of
   task automatic realign();
      while (tracker.record_position() != 0) push_byte(8'($urandom));
   endtask

   task automatic reconfigure();
      logic signed [31:0] xl, xh, yl, yh;
      logic [31:0]        count_word;
      case ($urandom_range(4))
         0: begin
            xl = 0; xh = 32'sh0001_0000; yl = 0; yh = 32'sh0001_0000;
         end
         1: begin
            xl = VALUE_MIN; xh = VALUE_MAX; yl = VALUE_MAX; yh = VALUE_MIN;
         end
         2: begin
            xl = VALUE_MAX; xh = VALUE_MIN; yl = VALUE_MIN; yh = VALUE_MAX;
         end
         3: begin
            xl = $urandom; xh = xl; yl = $urandom; yh = yl;
         end
         default: begin
            xl = $urandom; xh = $urandom; yl = $urandom; yh = $urandom;
         end
      endcase
      count_word      = $urandom;
      count_word[2:0] = 3'($urandom_range(7));
      write_csr(REG_COMPONENT_COUNT, count_word);
      write_csr(REG_X_RANGE_LOW, xl);
      write_csr(REG_X_RANGE_HIGH, xh);
      write_csr(REG_Y_RANGE_LOW, yl);
      write_csr(REG_Y_RANGE_HIGH, yh);
      // indexes past the bank must be ignored
      if ($urandom_range(1))
         write_csr(3'($urandom_range(7, REG_Y_RANGE_HIGH + 1)), $urandom);
   endtask

   initial begin
      int          phase;
      int unsigned phase_words;
      int unsigned phase_vertices;
      int unsigned config_mark;
      int          i;

      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // repeats straight after reset pull zero vertices from history
      send_record(FLAG_REPEAT_LAST, 24'hFF_FFFF, 24'h00_0000,
                  {16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF}, tracker.effective_count());
      send_record(FLAG_REPEAT_FIRST, 24'h00_0000, 24'hFF_FFFF,
                  pick_colours(), tracker.effective_count());

      // count of zero acts as one, full and reversed spans
      wait_drained();
      write_csr(REG_COMPONENT_COUNT, 32'd0);
      write_csr(REG_X_RANGE_LOW, VALUE_MIN);
      write_csr(REG_X_RANGE_HIGH, VALUE_MAX);
      write_csr(REG_Y_RANGE_LOW, VALUE_MAX);
      write_csr(REG_Y_RANGE_HIGH, VALUE_MIN);
      send_record(FLAG_NEW, 24'hFF_FFFF, 24'hFF_FFFF, {4{16'hFFFF}}, tracker.effective_count());
      send_record(FLAG_NEW, 24'h00_0000, 24'h00_0000, '0, tracker.effective_count());
      send_record(FLAG_ALL_ONES, pick_coord(), pick_coord(), pick_colours(),
                  tracker.effective_count());
      send_record(FLAG_REPEAT_LAST, 24'h80_0000, 24'h7F_FFFF, pick_colours(),
                  tracker.effective_count());

      // count written mid-record only applies from the next flag word
      push_byte(FLAG_REPEAT_FIRST);
      for (i = 0; i < 3; i++) push_byte(8'($urandom));
      wait_drained();
      write_csr(REG_COMPONENT_COUNT, 32'd7);
      realign();
      send_record(FLAG_NEW, pick_coord(), pick_coord(), pick_colours(),
                  tracker.effective_count());

      // random traffic in three phases with different idle rates
      config_mark = words_sent;
      for (phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 84;
            recv_idle_pct = 38;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         phase_words    = words_sent;
         phase_vertices = tracker.predicted_count;
         while (words_sent - phase_words < 40 ||
                tracker.predicted_count - phase_vertices < 5) begin
            if (words_sent - config_mark >= 40) begin
               wait_drained();
               reconfigure();
               config_mark = words_sent;
            end
            if ($urandom_range(99) < 12) begin
               // misaligning burst, then finish the broken record
               repeat ($urandom_range(12, 1)) push_byte(8'($urandom));
               realign();
            end else begin
               send_random_record();
            end
         end
      end

      wait_drained();
      tracker.close_out();
      if (tracker.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
